/* design/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ZSW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ZSW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/zsw_pkg.sv */
// Types, constants and coefficient table of the z-score int8 window block.
package zsw_pkg;

	typedef enum logic [1:0] {
		MODE_PUSH    = 2'd0,
		MODE_READ    = 2'd1,
		MODE_CONSUME = 2'd2,
		MODE_NOP     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_PUSH = 2'd1,
		OP_READ = 2'd2
	} op_t;

	typedef struct packed {
		mode_t              mode;
		logic signed [31:0] raw_sample;
		logic        [4:0]  read_row;
		logic        [3:0]  read_column;
	} in_t;

	typedef struct packed {
		logic signed [7:0] quantized_value;
		logic        [3:0] feature_slot;
		logic        [4:0] rows_filled;
		logic              window_full;
		logic              saturated;
	} out_t;

	typedef struct packed {
		op_t        op;
		logic       rd_zero;
		logic [3:0] slot;
		logic [4:0] rows;
		logic       ready;
	} meta_t;

	localparam int OFFSET_FRAC   = 16;
	localparam int GAIN_FRAC     = 14;
	localparam int DIFF_HEADROOM = 12;
	localparam int GAIN_W        = 24;
	localparam int OFFSET_W      = 24;

	localparam logic signed [7:0] ZP_RESET = -8'sd20;
	localparam logic signed [7:0] Q_MAX    = 8'sd127;
	localparam logic signed [7:0] Q_MIN    = -8'sd128;

	typedef struct packed {
		logic        [GAIN_W-1:0]   gain;
		logic signed [OFFSET_W-1:0] offset;
	} coef_t;

	function automatic coef_t coef_lookup(logic [3:0] idx);
		coef_t c;
		case (idx)
			4'd0:  begin c.gain = 24'd334373;  c.offset = 24'sd232150;   end
			4'd1:  begin c.gain = 24'd474790;  c.offset = -24'sd11659;   end
			4'd2:  begin c.gain = 24'd1004548; c.offset = 24'sd55572;    end
			4'd3:  begin c.gain = 24'd1029723; c.offset = -24'sd53869;   end
			4'd4:  begin c.gain = 24'd4697464; c.offset = 24'sd15699;    end
			4'd5:  begin c.gain = 24'd1581564; c.offset = 24'sd3550;     end
			4'd6:  begin c.gain = 24'd4726096; c.offset = 24'sd15660;    end
			4'd7:  begin c.gain = 24'd45782;   c.offset = 24'sd3191317;  end
			4'd8:  begin c.gain = 24'd326484;  c.offset = 24'sd219386;   end
			4'd9:  begin c.gain = 24'd551174;  c.offset = -24'sd380;     end
			4'd10: begin c.gain = 24'd791545;  c.offset = 24'sd72161;    end
			4'd11: begin c.gain = 24'd675705;  c.offset = -24'sd80734;   end
			4'd12: begin c.gain = 24'd2851935; c.offset = 24'sd21626;    end
			4'd13: begin c.gain = 24'd1497153; c.offset = -24'sd10712;   end
			4'd14: begin c.gain = 24'd2856354; c.offset = 24'sd21565;    end
			default: begin c.gain = 24'd46490; c.offset = 24'sd3352165;  end
		endcase
		return c;
	endfunction

endpackage

/* design/zsw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module zsw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 480,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/zscore_int8_sliding_window.sv */
// Top level: z-score normalizer, int8 quantizer and sliding row window.
// Input channel in_valid / in_stall / in_data carries one command per transfer:
// push a raw feature (16 fraction bits), read a window element, consume, or do nothing (NOP).
// Output channel out_valid / out_stall / out_data returns exactly one result
// per command, in order: the quantized value and saturation flag of a push, the
// stored element of a read, plus the column, row count and ready flag.
// A command passes through the three stages (align and clamp, multiply, round
// and window RAM access) to output valid, and each stage holds one command. One
// command is taken every cycle while in_stall is low, and the window RAM does one
// write or one read per cycle in the last stage.
// The zero point register is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while the block is idle, as the block itself does not enforce it.
// Reset clears the row count, column count, oldest-row pointer and ready flag
// and sets the zero point to -20; window contents are undefined until pushed.
// When out_stall is high the output result holds; the stages behind it keep
// filling and in_stall rises once all three are occupied.
module zscore_int8_sliding_window #(
	parameter int WINDOW_ROWS          = 30,
	parameter int FEATURE_COUNT        = 16,
	parameter int SAMPLE_FRACTION_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  zsw_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output zsw_pkg::out_t out_data,
	input  logic          cfg_wr_en,
	input  logic [7:0]    cfg_wr_data
);

	import zsw_pkg::*;

	localparam int FB   = (SAMPLE_FRACTION_BITS > OFFSET_FRAC) ? SAMPLE_FRACTION_BITS
		: OFFSET_FRAC;
	localparam int RS   = FB + GAIN_FRAC;
	localparam int XW   = 32 + FB - SAMPLE_FRACTION_BITS;
	localparam int OW   = OFFSET_W + FB - OFFSET_FRAC;
	localparam int DW   = ((XW > OW) ? XW : OW) + 1;
	localparam int CW   = FB + DIFF_HEADROOM + 2;
	localparam int EW   = (DW > CW) ? DW : CW;
	localparam int PW   = CW + GAIN_W + 1;
	localparam int SW   = PW + 1;
	localparam int FLW  = SW - RS;
	localparam int CCW  = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
	localparam int COLW = (CCW > 4) ? CCW : 4;
	localparam int PTRW = (WINDOW_ROWS > 1) ? $clog2(WINDOW_ROWS) : 1;
	localparam int CNTW = $clog2(WINDOW_ROWS + 1);
	localparam int RSW  = ((CNTW > 5) ? CNTW : 5) + 1;
	localparam int DEPTH = WINDOW_ROWS * FEATURE_COUNT;
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [CCW-1:0]  LAST_COL = CCW'(FEATURE_COUNT - 1);
	localparam logic [CNTW-1:0] W_CNT    = CNTW'(WINDOW_ROWS);
	localparam logic [PTRW-1:0] LAST_PTR = PTRW'(WINDOW_ROWS - 1);
	localparam logic [RSW-1:0]  W_SUM    = RSW'(WINDOW_ROWS);
	localparam logic [AW-1:0]   FC_A     = AW'(FEATURE_COUNT);
	localparam logic signed [EW-1:0] LIM_P = EW'(1) <<< (FB + DIFF_HEADROOM);
	localparam logic signed [EW-1:0] LIM_N = -LIM_P;
	localparam logic signed [FLW:0]  Q_HI  = (FLW + 1)'(127);
	localparam logic signed [FLW:0]  Q_LO  = (FLW + 1)'(-128);

	// architectural state
	logic [PTRW-1:0]   oldest_q, oldest_n;
	logic [CNTW-1:0]   rows_q, rows_n;
	logic [CCW-1:0]    col_q, col_n;
	logic              ready_q, ready_n;
	logic signed [7:0] zp_q;

	// pipeline
	logic                v_s1, v_s2, v_s3;
	logic                en1, en2, en3, acc;
	meta_t               meta_s0, meta_s1, meta_s2, meta_s3;
	logic signed [CW-1:0] diff_s0, diff_s1;
	logic [GAIN_W-1:0]   gain_s1;
	logic [PTRW-1:0]     row_s0, row_s1;
	logic [COLW-1:0]     colx_s0, colx_s1;
	logic signed [PW-1:0] prod_s2;
	logic [AW-1:0]       addr_s2;
	logic signed [7:0]   val_s3;
	logic                sat_s3;

	// stage 0 datapath
	coef_t                coef;
	logic [COLW-1:0]      col_x;
	logic signed [EW-1:0] xs, os, diff;
	logic [RSW-1:0]       push_sum, read_sum;
	logic [PTRW-1:0]      push_row, read_row_p;
	logic                 read_ok;

	// stage 2 datapath
	logic signed [SW-1:0] sum_s2;
	logic signed [FLW:0]  qr_s2;
	logic                 rnd_s2, sat_s2;
	logic signed [7:0]    q8_s2;
	logic                 ram_we, ram_re;
	logic [7:0]           ram_q;

	assign en3      = !v_s3 || !out_stall;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;
	assign acc      = in_valid && en1;

	always_comb begin
		col_x = COLW'(col_q);
		coef  = coef_lookup(col_x[3:0]);
		xs    = EW'($signed(in_data.raw_sample)) <<< (FB - SAMPLE_FRACTION_BITS);
		os    = EW'($signed(coef.offset)) <<< (FB - OFFSET_FRAC);
		diff  = xs - os;
		if (diff > LIM_P) begin
			diff_s0 = CW'(LIM_P);
		end else if (diff < LIM_N) begin
			diff_s0 = CW'(LIM_N);
		end else begin
			diff_s0 = CW'(diff);
		end

		push_sum = RSW'(oldest_q) + RSW'(rows_q);
		if (rows_q < W_CNT) begin
			push_row = (push_sum >= W_SUM) ? PTRW'(push_sum - W_SUM) : PTRW'(push_sum);
		end else begin
			push_row = oldest_q;
		end
		read_sum   = RSW'(oldest_q) + RSW'(in_data.read_row);
		read_row_p = (read_sum >= W_SUM) ? PTRW'(read_sum - W_SUM) : PTRW'(read_sum);
		read_ok    = (32'(in_data.read_row) < WINDOW_ROWS)
			&& (32'(in_data.read_column) < FEATURE_COUNT);
	end

	always_comb begin
		oldest_n        = oldest_q;
		rows_n          = rows_q;
		col_n           = col_q;
		ready_n         = ready_q;
		meta_s0.op      = OP_NONE;
		meta_s0.rd_zero = 1'b0;
		meta_s0.slot    = '0;
		row_s0          = push_row;
		colx_s0         = col_x;
		unique case (in_data.mode)
			MODE_PUSH: begin
				meta_s0.op   = OP_PUSH;
				meta_s0.slot = 4'(col_q);
				if (col_q == LAST_COL) begin
					col_n = '0;
					if (rows_q < W_CNT) begin
						rows_n = CNTW'(rows_q + 1'b1);
						if (CNTW'(rows_q + 1'b1) == W_CNT) begin
							ready_n = 1'b1;
						end
					end else begin
						oldest_n = (oldest_q == LAST_PTR) ? '0 : PTRW'(oldest_q + 1'b1);
						ready_n  = 1'b1;
					end
				end else begin
					col_n = CCW'(col_q + 1'b1);
				end
			end
			MODE_READ: begin
				meta_s0.op      = OP_READ;
				meta_s0.slot    = in_data.read_column;
				meta_s0.rd_zero = !read_ok;
				row_s0          = read_row_p;
				colx_s0         = COLW'(in_data.read_column);
			end
			MODE_CONSUME: begin
				rows_n  = '0;
				col_n   = '0;
				ready_n = 1'b0;
			end
			MODE_NOP: begin
			end
		endcase
		meta_s0.rows  = 5'(rows_n);
		meta_s0.ready = ready_n;
	end

	always_comb begin
		sum_s2 = SW'(prod_s2) + (SW'(zp_q) <<< RS);
		rnd_s2 = sum_s2[RS-1] && ((|sum_s2[RS-2:0]) || sum_s2[RS]);
		qr_s2  = $signed({sum_s2[SW-1], sum_s2[SW-1:RS]}) + $signed({{FLW{1'b0}}, rnd_s2});
		if (qr_s2 > Q_HI) begin
			q8_s2  = Q_MAX;
			sat_s2 = 1'b1;
		end else if (qr_s2 < Q_LO) begin
			q8_s2  = Q_MIN;
			sat_s2 = 1'b1;
		end else begin
			q8_s2  = qr_s2[7:0];
			sat_s2 = 1'b0;
		end
	end

	assign ram_we = en3 && v_s2 && (meta_s2.op == OP_PUSH);
	assign ram_re = en3 && v_s2 && (meta_s2.op == OP_READ) && !meta_s2.rd_zero;

	zsw_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_window_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s2),
		.wdata (q8_s2),
		.re    (ram_re),
		.raddr (addr_s2),
		.rdata (ram_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			oldest_q <= '0;
			rows_q   <= '0;
			col_q    <= '0;
			ready_q  <= 1'b0;
			zp_q     <= ZP_RESET;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (acc) begin
				oldest_q <= oldest_n;
				rows_q   <= rows_n;
				col_q    <= col_n;
				ready_q  <= ready_n;
			end
			if (cfg_wr_en) begin
				zp_q <= $signed(cfg_wr_data);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			meta_s1 <= meta_s0;
			diff_s1 <= diff_s0;
			gain_s1 <= coef.gain;
			row_s1  <= row_s0;
			colx_s1 <= colx_s0;
		end
		if (en2 && v_s1) begin
			meta_s2 <= meta_s1;
			prod_s2 <= PW'(diff_s1) * PW'($signed({1'b0, gain_s1}));
			addr_s2 <= AW'(row_s1) * FC_A + AW'(colx_s1);
		end
		if (en3 && v_s2) begin
			meta_s3 <= meta_s2;
			val_s3  <= (meta_s2.op == OP_PUSH) ? q8_s2 : 8'sd0;
			sat_s3  <= (meta_s2.op == OP_PUSH) && sat_s2;
		end
	end

	assign out_valid                = v_s3;
	assign out_data.quantized_value = ((meta_s3.op == OP_READ) && !meta_s3.rd_zero)
		? $signed(ram_q) : val_s3;
	assign out_data.feature_slot    = meta_s3.slot;
	assign out_data.rows_filled     = meta_s3.rows;
	assign out_data.window_full     = meta_s3.ready;
	assign out_data.saturated       = sat_s3;

endmodule

/* design/zsw_checker.sv */
// Port-level checker for the z-score int8 window block, with its bind.
`include "assert_macros.svh"

module zsw_checker #(
	parameter int WINDOW_ROWS = 30
) (
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_stall,
	input zsw_pkg::out_t out_data
);

	`ZSW_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_data), "stalled output transfer changed")

	`ZSW_ASSERT_IMPL(a_rows_bound, clk, arst_n, out_valid,
		(WINDOW_ROWS > 31) || (32'(out_data.rows_filled) <= WINDOW_ROWS),
		"row count beyond window length")

	`ZSW_ASSERT_IMPL(a_ready_full, clk, arst_n, out_valid,
		(WINDOW_ROWS > 31) || (out_data.window_full == (32'(out_data.rows_filled) == WINDOW_ROWS)),
		"ready flag disagrees with full row count")

	`ZSW_ASSERT_IMPL(a_sat_limit, clk, arst_n, out_valid && out_data.saturated,
		(out_data.quantized_value == 8'sd127) || (out_data.quantized_value == -8'sd128),
		"saturated value not at an int8 limit")

endmodule

bind zscore_int8_sliding_window zsw_checker #(
	.WINDOW_ROWS (WINDOW_ROWS)
) u_zsw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

/* verif/zscore_int8_sliding_window_tb.sv */
// Testbench for zscore_int8_sliding_window: random and directed commands, self-checking.
`timescale 1ns / 100ps

module zscore_int8_sliding_window_tb;
	import zsw_pkg::*;

	localparam int     WIN_ROWS     = 30;
	localparam int     FEATURES     = 16;
	localparam int     PRODUCT_FRAC = 30;
	localparam longint DIFF_LIM     = 64'sd1 <<< 28;
	localparam longint HALF_LSB     = 64'sd1 <<< (PRODUCT_FRAC - 1);
	localparam int     PHASE_ITEMS  = 200;
	localparam int     PHASES       = 8;
	localparam int     LIMIT_CYCLES = 400000;
	localparam int     PRINT_CAP    = 40;

	localparam longint GAIN_TBL [FEATURES] = '{
		334373, 474790, 1004548, 1029723, 4697464, 1581564, 4726096, 45782,
		326484, 551174, 791545, 675705, 2851935, 1497153, 2856354, 46490
	};
	localparam longint OFFSET_TBL [FEATURES] = '{
		232150, -11659, 55572, -53869, 15699, 3550, 15660, 3191317,
		219386, -380, 72161, -80734, 21626, -10712, 21565, 3352165
	};

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	in_t               in_data     = '0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	out_t              out_data;
	logic              cfg_wr_en   = 1'b0;
	logic [7:0]        cfg_wr_data = '0;

	in_t               queued_commands [$];
	out_t              predicted_outputs [$];
	int                err_count;
	int                cycle_count;

	logic signed [7:0] model_cells [WIN_ROWS*FEATURES];
	int                model_oldest;
	int                model_rows;
	int                model_col;
	bit                model_ready;
	logic signed [7:0] model_zp = -8'sd20;

	bit                plan_filled [WIN_ROWS*FEATURES];
	int                plan_oldest;
	int                plan_rows;
	int                plan_col;

	int                tx_gap;
	int                tx_run;
	bit                tx_quiet;
	int                rx_hold;
	int                rx_run;
	bit                rx_quiet;

	zscore_int8_sliding_window i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic signed [7:0] zscore_quantize(logic signed [31:0] smp, int col,
			logic signed [7:0] zpt, output bit clipped);
		longint diff;
		longint acc;
		longint fl;
		longint rem;
		diff = longint'(smp) - OFFSET_TBL[col];
		if (diff > DIFF_LIM) diff = DIFF_LIM;
		if (diff < -DIFF_LIM) diff = -DIFF_LIM;
		acc = diff * GAIN_TBL[col] + (longint'(zpt) <<< PRODUCT_FRAC);
		fl = acc >>> PRODUCT_FRAC;
		rem = acc & ((64'sd1 <<< PRODUCT_FRAC) - 1);
		if (rem > HALF_LSB || (rem == HALF_LSB && fl[0])) fl++;
		clipped = 1'b0;
		if (fl > 127) begin
			fl = 127;
			clipped = 1'b1;
		end
		if (fl < -128) begin
			fl = -128;
			clipped = 1'b1;
		end
		return fl[7:0];
	endfunction

	function automatic out_t zscore_window_predict(in_t cmd);
		out_t res;
		int prow;
		bit clipped;
		res = '0;
		case (cmd.mode)
			MODE_PUSH: begin
				prow = (model_rows < WIN_ROWS) ? (model_oldest + model_rows) % WIN_ROWS
					: model_oldest;
				res.quantized_value = zscore_quantize(cmd.raw_sample, model_col, model_zp, clipped);
				res.saturated = clipped;
				res.feature_slot = model_col[3:0];
				model_cells[prow*FEATURES + model_col] = res.quantized_value;
				if (model_col == FEATURES - 1) begin
					model_col = 0;
					if (model_rows < WIN_ROWS) begin
						model_rows++;
						if (model_rows == WIN_ROWS) model_ready = 1'b1;
					end else begin
						model_oldest = (model_oldest + 1) % WIN_ROWS;
						model_ready = 1'b1;
					end
				end else begin
					model_col++;
				end
			end
			MODE_READ: begin
				res.feature_slot = cmd.read_column;
				if (cmd.read_row < WIN_ROWS)
					res.quantized_value = model_cells[((model_oldest + cmd.read_row) % WIN_ROWS)
						* FEATURES + cmd.read_column];
			end
			MODE_CONSUME: begin
				model_rows = 0;
				model_col = 0;
				model_ready = 1'b0;
			end
			default: ;
		endcase
		res.rows_filled = model_rows[4:0];
		res.window_full = model_ready;
		return res;
	endfunction

	function automatic in_t make_cmd(mode_t m, logic [31:0] smp, logic [4:0] row, logic [3:0] col);
		in_t cmd;
		cmd.mode = m;
		cmd.raw_sample = smp;
		cmd.read_row = row;
		cmd.read_column = col;
		return cmd;
	endfunction

	function automatic int draw_wait(inout int run, inout bit quiet);
		if (run == 0) begin
			run = $urandom_range(10, 60);
			quiet = ($urandom_range(0, 2) == 0);
		end
		run--;
		return quiet ? 0 : $urandom_range(0, 11);
	endfunction

	function automatic logic [31:0] push_sample(int col);
		longint span;
		longint smp;
		int pick;
		pick = $urandom_range(0, 99);
		span = (64'sd1 <<< PRODUCT_FRAC) * 150 / GAIN_TBL[col];
		if (pick < 65) begin
			smp = OFFSET_TBL[col] + longint'($urandom_range(0, 32'(2 * span))) - span;
		end else if (pick < 80) begin
			smp = longint'($urandom);
		end else if (pick < 90) begin
			smp = OFFSET_TBL[col] + (($urandom_range(0, 1) == 1) ? DIFF_LIM : -DIFF_LIM)
				+ longint'(int'($urandom_range(0, 6))) - 3;
		end else begin
			case ($urandom_range(0, 3))
				0: smp = 32'h7fff_ffff;
				1: smp = -(64'sd1 <<< 31);
				2: smp = 0;
				default: smp = OFFSET_TBL[col];
			endcase
		end
		return smp[31:0];
	endfunction

	task automatic queue_cmd(in_t cmd);
		int prow;
		case (cmd.mode)
			MODE_PUSH: begin
				prow = (plan_rows < WIN_ROWS) ? (plan_oldest + plan_rows) % WIN_ROWS : plan_oldest;
				plan_filled[prow*FEATURES + plan_col] = 1'b1;
				if (plan_col == FEATURES - 1) begin
					plan_col = 0;
					if (plan_rows < WIN_ROWS) plan_rows++;
					else plan_oldest = (plan_oldest + 1) % WIN_ROWS;
				end else begin
					plan_col++;
				end
			end
			MODE_CONSUME: begin
				plan_rows = 0;
				plan_col = 0;
			end
			default: ;
		endcase
		queued_commands.push_back(cmd);
	endtask

	task automatic queue_read(int row, int col);
		if (row < WIN_ROWS && !plan_filled[((plan_oldest + row) % WIN_ROWS) * FEATURES + col])
			row = WIN_ROWS + $urandom_range(0, 1);
		queue_cmd(make_cmd(MODE_READ, $urandom, row[4:0], col[3:0]));
	endtask

	task automatic queue_random_cmd();
		int pick;
		int row;
		pick = $urandom_range(0, 999);
		if (pick < 700) begin
			queue_cmd(make_cmd(MODE_PUSH, push_sample(plan_col), 5'($urandom), 4'($urandom)));
		end else if (pick < 960) begin
			case ($urandom_range(0, 9))
				0: row = WIN_ROWS + $urandom_range(0, 1);
				1, 2, 3: row = 0;
				default: row = $urandom_range(0, WIN_ROWS - 1);
			endcase
			queue_read(row, $urandom_range(0, FEATURES - 1));
		end else if (pick < 990 || $urandom_range(0, (plan_rows == WIN_ROWS) ? 3 : 60) != 0) begin
			queue_cmd(make_cmd(MODE_NOP, $urandom, 5'($urandom), 4'($urandom)));
		end else begin
			queue_cmd(make_cmd(MODE_CONSUME, $urandom, 5'($urandom), 4'($urandom)));
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (queued_commands.size() != 0 || in_valid || predicted_outputs.size() != 0);
	endtask

	task automatic note_mismatch(string field, logic signed [31:0] want, logic signed [31:0] got);
		err_count++;
		if (err_count <= PRINT_CAP)
			$display("%0t %s: expected %0d, actual %0d", $time, field, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			tx_gap = 0;
		end else if (!in_valid || !in_stall) begin
			if (tx_gap != 0) begin
				tx_gap--;
				in_valid <= 1'b0;
			end else if (queued_commands.size() != 0) begin
				in_data <= queued_commands.pop_front();
				in_valid <= 1'b1;
				tx_gap = draw_wait(tx_run, tx_quiet);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_hold = 0;
		end else begin
			if (in_valid && !in_stall)
				predicted_outputs.push_back(zscore_window_predict(in_data));
			if (out_valid && !out_stall) begin
				if (predicted_outputs.size() == 0) begin
					err_count++;
					if (err_count <= PRINT_CAP)
						$display("%0t unexpected transfer: expected none, actual %h", $time, out_data);
				end else begin
					want = predicted_outputs.pop_front();
					if (out_data.quantized_value !== want.quantized_value)
						note_mismatch("quantized_value", 32'(want.quantized_value),
							32'(out_data.quantized_value));
					if (out_data.feature_slot !== want.feature_slot)
						note_mismatch("feature_slot", 32'(want.feature_slot),
							32'(out_data.feature_slot));
					if (out_data.rows_filled !== want.rows_filled)
						note_mismatch("rows_filled", 32'(want.rows_filled),
							32'(out_data.rows_filled));
					if (out_data.window_full !== want.window_full)
						note_mismatch("window_full", 32'(want.window_full),
							32'(out_data.window_full));
					if (out_data.saturated !== want.saturated)
						note_mismatch("saturated", 32'(want.saturated),
							32'(out_data.saturated));
				end
				rx_hold = draw_wait(rx_run, rx_quiet);
			end
			if (rx_hold != 0) begin
				rx_hold--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("zscore_int8_sliding_window: mismatch");
			$finish;
		end
	end

	initial begin
		logic signed [7:0] zp_steps [PHASES];
		logic [31:0] smp;
		zp_steps = '{-8'sd20, 8'sd127, -8'sd128, 8'sd0, 8'sd5, -8'sd1, 8'sd64, -8'sd77};
		zp_steps[4] = 8'($urandom);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (int c = 0; c < FEATURES; c++) begin
			case (c)
				0: smp = 32'h7fff_ffff;
				1: smp = 32'h8000_0000;
				2: smp = '0;
				3: smp = '1;
				7: smp = 32'(OFFSET_TBL[c] + DIFF_LIM + 3);
				8: smp = 32'(OFFSET_TBL[c] - DIFF_LIM - 3);
				default: smp = 32'(OFFSET_TBL[c] + (c - 8) * 997);
			endcase
			queue_cmd(make_cmd(MODE_PUSH, smp, 5'h1f, 4'h0));
		end
		queue_read(0, 0);
		queue_read(0, FEATURES - 1);
		queue_read(31, 9);
		queue_read(WIN_ROWS, 0);
		queue_cmd(make_cmd(MODE_NOP, '1, 5'h1f, 4'hf));
		queue_cmd(make_cmd(MODE_CONSUME, '0, 5'h0, 4'h0));
		queue_read(0, 7);
		queue_cmd(make_cmd(MODE_PUSH, 32'(OFFSET_TBL[0]), 5'h0, 4'h0));
		queue_cmd(make_cmd(MODE_CONSUME, '1, 5'h1f, 4'hf));
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			@(posedge clk);
			cfg_wr_en <= 1'b1;
			cfg_wr_data <= zp_steps[p];
			model_zp = zp_steps[p];
			@(posedge clk);
			cfg_wr_en <= 1'b0;
			for (int i = 0; i < PHASE_ITEMS; i++)
				queue_random_cmd();
			wait_idle();
		end

		repeat (12) @(posedge clk);
		if (err_count == 0 && predicted_outputs.size() == 0)
			$display("zscore_int8_sliding_window: match");
		else
			$display("zscore_int8_sliding_window: mismatch");
		$finish;
	end

endmodule
